// ===== rtl/cbfi_pkg.sv =====
// Shared types, constants and blend arithmetic for the cubic Bezier frame interpolator.
// Depends on nothing; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cbfi_pkg;

    localparam int POINTS   = 512;
    localparam int SUBSTEPS = 21;
    localparam int SW       = 16;
    localparam int KW       = 16;
    localparam int PW       = 9;
    localparam int SUB_W    = 5;
    localparam int SLOTS    = 4;
    localparam int ROW_AW   = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int ROUND    = 1 << (KW - 1);

    localparam logic [1:0] SLOT_RESET = 2'd3;

    typedef logic signed [SW-1:0] sample_t;
    typedef logic [KW-1:0]        coef_t;
    typedef logic [ROW_AW-1:0]    row_addr_t;

    typedef struct packed {
        sample_t x;
        sample_t y;
    } point_t;

    typedef point_t [SLOTS-1:0] row_t;

    typedef struct packed {
        logic signed [SW-1:0] x_value;
        logic signed [SW-1:0] y_value;
        logic [PW-1:0]        point_index;
        logic                 sample_valid;
        logic                 new_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [SW-1:0] x_out;
        logic signed [SW-1:0] y_out;
        logic [PW-1:0]        out_point;
        logic [SUB_W-1:0]     sub_index;
        logic                 last;
    } out_item_t;

    // ctrl[0] is the newest frame, ctrl[3] the oldest
    typedef struct packed {
        point_t [SLOTS-1:0] ctrl;
        logic [PW-1:0]      point;
    } curve_t;

    typedef logic [SUBSTEPS-1:0][KW-1:0] k_lut_t;

    function automatic k_lut_t build_k_lut();
        k_lut_t lut;
        for (int j = 0; j < SUBSTEPS; j++)
        begin
            lut[j] = KW'((j * (1 << KW) + SUBSTEPS / 2) / SUBSTEPS);
        end
        return lut;
    endfunction

    localparam k_lut_t K_LUT = build_k_lut();

    function automatic row_addr_t row_of(logic [PW-1:0] p);
        return ROW_AW'(p % POINTS);
    endfunction

    // a + round((b - a) * k / 2^KW), half up
    function automatic sample_t blend(sample_t a, sample_t b, coef_t k);
        logic signed [SW:0]      diff;
        logic signed [SW+KW+1:0] prod;
        logic signed [SW+KW+1:0] acc;
        diff = (SW+1)'(b) - (SW+1)'(a);
        prod = diff * $signed({1'b0, k});
        acc  = (prod + (SW+KW+2)'(ROUND)) >>> KW;
        acc  = acc + (SW+KW+2)'(a);
        return acc[SW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cbfi_history.sv =====
// Point history memory: clear sweep, row read, sample merge and write-back.
// Hands the four control points of each item to the curve generator. Uses cbfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbfi_history
    import cbfi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire in_item_t item,
    output logic          curve_valid,
    input  wire logic     curve_take,
    output curve_t        curve
);

    row_t      mem [POINTS];

    logic      clr_active_reg;
    row_addr_t clr_addr_reg;
    logic [1:0] slot_reg;
    logic [1:0] slot_next;
    logic      rd_vld_reg;
    in_item_t  rd_item_reg;
    logic [1:0] rd_slot_reg;
    row_addr_t rd_row_reg;
    row_t      rd_data_reg;
    logic      hold_vld_reg;
    curve_t    hold_reg;

    logic      accept;
    row_t      merged;
    curve_t    curve_next;
    logic      wr_en;
    row_addr_t wr_addr;
    row_t      wr_data;

    assign item_ready  = !clr_active_reg && !rd_vld_reg && (!hold_vld_reg || curve_take);
    assign accept      = item_valid && item_ready;
    assign slot_next   = slot_reg + {1'b0, item.new_frame};
    assign curve_valid = hold_vld_reg;
    assign curve       = hold_reg;

    always_comb
    begin
        merged = rd_data_reg;
        if (rd_item_reg.sample_valid)
        begin
            merged[rd_slot_reg] = '{x: rd_item_reg.x_value, y: rd_item_reg.y_value};
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            curve_next.ctrl[i] = merged[rd_slot_reg - 2'(i)];
        end
        curve_next.point = rd_item_reg.point_index;
    end

    assign wr_en   = clr_active_reg || rd_vld_reg;
    assign wr_addr = clr_active_reg ? clr_addr_reg : rd_row_reg;
    assign wr_data = clr_active_reg ? '0 : merged;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= mem[row_of(item.point_index)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            slot_reg       <= SLOT_RESET;
            rd_vld_reg     <= 1'b0;
            hold_vld_reg   <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ROW_AW'(POINTS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                slot_reg <= slot_next;
            end
            rd_vld_reg   <= accept;
            hold_vld_reg <= rd_vld_reg || (hold_vld_reg && !curve_take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_item_reg <= item;
            rd_slot_reg <= slot_next;
            rd_row_reg  <= row_of(item.point_index);
        end
        if (rd_vld_reg)
        begin
            hold_reg <= curve_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cbfi_curve_gen.sv =====
// Substep sequencer and three-level de Casteljau blend pipeline with output register.
// Takes control points from cbfi_history. Uses cbfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbfi_curve_gen
    import cbfi_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   curve_valid,
    output logic        curve_take,
    input  wire curve_t curve,
    output logic        result_valid,
    input  wire logic   result_ready,
    output out_item_t   result
);

    logic             act_reg;
    logic [SUB_W-1:0] j_reg;
    curve_t           cur_reg;

    logic             v1_reg;
    coef_t            k1_reg;
    logic [SUB_W-1:0] j1_reg;
    logic [PW-1:0]    pt1_reg;
    sample_t [2:0]    x1_reg;
    sample_t [2:0]    y1_reg;

    logic             v2_reg;
    coef_t            k2_reg;
    logic [SUB_W-1:0] j2_reg;
    logic [PW-1:0]    pt2_reg;
    sample_t [1:0]    x2_reg;
    sample_t [1:0]    y2_reg;

    logic             v3_reg;
    out_item_t        result_reg;
    out_item_t        result_next;

    logic             en;
    logic             issue;
    logic             last_j;
    coef_t            k0;

    assign en           = !v3_reg || result_ready;
    assign issue        = act_reg && en;
    assign last_j       = (j_reg == SUB_W'(SUBSTEPS - 1));
    assign curve_take   = curve_valid && (!act_reg || (issue && last_j));
    assign k0           = K_LUT[j_reg];
    assign result_valid = v3_reg;
    assign result       = result_reg;

    always_comb
    begin
        result_next.x_out     = blend(x2_reg[0], x2_reg[1], k2_reg);
        result_next.y_out     = blend(y2_reg[0], y2_reg[1], k2_reg);
        result_next.out_point = pt2_reg;
        result_next.sub_index = j2_reg;
        result_next.last      = (j2_reg == SUB_W'(SUBSTEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            j_reg   <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            if (curve_take)
            begin
                act_reg <= 1'b1;
                j_reg   <= '0;
            end
            else if (issue && last_j)
            begin
                act_reg <= 1'b0;
            end
            else if (issue)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (en)
            begin
                v1_reg <= act_reg;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (curve_take)
        begin
            cur_reg <= curve;
        end
        if (en)
        begin
            k1_reg    <= k0;
            j1_reg    <= j_reg;
            pt1_reg   <= cur_reg.point;
            x1_reg[0] <= blend(cur_reg.ctrl[0].x, cur_reg.ctrl[1].x, k0);
            x1_reg[1] <= blend(cur_reg.ctrl[1].x, cur_reg.ctrl[2].x, k0);
            x1_reg[2] <= blend(cur_reg.ctrl[2].x, cur_reg.ctrl[3].x, k0);
            y1_reg[0] <= blend(cur_reg.ctrl[0].y, cur_reg.ctrl[1].y, k0);
            y1_reg[1] <= blend(cur_reg.ctrl[1].y, cur_reg.ctrl[2].y, k0);
            y1_reg[2] <= blend(cur_reg.ctrl[2].y, cur_reg.ctrl[3].y, k0);

            k2_reg    <= k1_reg;
            j2_reg    <= j1_reg;
            pt2_reg   <= pt1_reg;
            x2_reg[0] <= blend(x1_reg[0], x1_reg[1], k1_reg);
            x2_reg[1] <= blend(x1_reg[1], x1_reg[2], k1_reg);
            y2_reg[0] <= blend(y1_reg[0], y1_reg[1], k1_reg);
            y2_reg[1] <= blend(y1_reg[1], y1_reg[2], k1_reg);

            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cubic_bezier_frame_interp.sv =====
// Top level of the cubic Bezier frame interpolator: history memory plus curve generator.
// Depends on cbfi_pkg, cbfi_history and cbfi_curve_gen.
//
//   beat       | signals                               | payload
//   -----------+---------------------------------------+------------------------------
//   item in    | item_valid / item_ready / item        | x, y sample, point, flags
//   result out | result_valid / result_ready / result  | x, y, point, substep, last
//
// Each item yields 21 result beats, one per cycle unless result_ready stalls the pipeline;
// the substep sequencer takes the next item as it issues the current item's last substep.
// The first result follows the item beat through row read, merge, load and 3 blend levels.
// After reset the history memory is zeroed one row per cycle with item_ready low, 512 rows.
// A stalled result beat holds the whole blend pipeline; the next item is fetched meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_frame_interp
    import cbfi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire in_item_t item,
    output logic          result_valid,
    input  wire logic     result_ready,
    output out_item_t     result
);

    logic   curve_valid;
    logic   curve_take;
    curve_t curve;

    cbfi_history u_history (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .curve_valid (curve_valid),
        .curve_take  (curve_take),
        .curve       (curve)
    );

    cbfi_curve_gen u_curve_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .curve_valid  (curve_valid),
        .curve_take   (curve_take),
        .curve        (curve),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/cbfi_checker.sv =====
// Port-level checks for cubic_bezier_frame_interp, attached by bind.
// Depends on cbfi_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module cbfi_checker
    import cbfi_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      item_valid,
    input wire logic      item_ready,
    input wire logic      result_valid,
    input wire logic      result_ready,
    input wire out_item_t result
);

    logic [SUB_W-1:0] exp_sub_reg;
    logic [PW-1:0]    pt_reg;
    logic [2:0]       pending_reg;
    logic             in_beat;
    logic             out_beat;
    logic             end_beat;

    assign in_beat  = item_valid && item_ready;
    assign out_beat = result_valid && result_ready;
    assign end_beat = out_beat && result.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_sub_reg <= '0;
            pt_reg      <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (out_beat)
            begin
                exp_sub_reg <= result.last ? '0 : exp_sub_reg + 1'b1;
                pt_reg      <= result.out_point;
            end
            pending_reg <= pending_reg + {2'b00, in_beat} - {2'b00, end_beat};
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.sub_index == exp_sub_reg)
        else $error("substep out of order");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last == (result.sub_index == SUB_W'(SUBSTEPS - 1))))
        else $error("last flag does not match final substep");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result beat without an outstanding item");

    a_point: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sub_index != '0 |-> result.out_point == pt_reg)
        else $error("point changed within one curve");

endmodule

bind cubic_bezier_frame_interp cbfi_checker u_cbfi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for cubic_bezier_frame_interp: drives sample beats and checks
// every interpolated result beat against a predictor of the four-frame Bezier history.
// Depends on cbfi_pkg and the cubic_bezier_frame_interp RTL.
`timescale 1ns / 1ps

module tb_top;
    import cbfi_pkg::*;

    localparam int      RANDOM_ITEMS = 360;
    localparam int      MAX_GAP      = 14;
    localparam int      IDLE_LIMIT   = 5000;
    localparam int      DRAIN_CYCLES = 40;
    localparam int      HOLD_AT      = 2000;
    localparam int      HOLD_CYCLES  = 600;
    localparam int      PRINT_CAP    = 40;
    localparam sample_t S_MAX        = 16'sh7FFF;
    localparam sample_t S_MIN        = 16'sh8000;
    localparam int      Q_ONE        = 1 << KW;

    typedef longint ctrl_t [SLOTS];

    class curve_checker;
        sample_t    hist_x [SLOTS*POINTS];
        sample_t    hist_y [SLOTS*POINTS];
        logic [1:0] slot;
        out_item_t  expected_steps [$];
        int         errors;

        function new();
            foreach (hist_x[i])
            begin
                hist_x[i] = '0;
                hist_y[i] = '0;
            end
            slot   = SLOT_RESET;
            errors = 0;
        endfunction

        function longint mix(longint a, longint b, longint k);
            longint s;
            s = a * (Q_ONE - k) + b * k + (Q_ONE / 2);
            return s >>> KW;
        endfunction

        function longint eval_curve(ctrl_t q, longint k);
            longint a, b, d;
            a = mix(q[0], q[1], k);
            b = mix(q[1], q[2], k);
            d = mix(q[2], q[3], k);
            a = mix(a, b, k);
            b = mix(b, d, k);
            return mix(a, b, k);
        endfunction

        function void note_item(in_item_t it);
            int        row;
            int        idx;
            longint    k;
            ctrl_t     qx;
            ctrl_t     qy;
            out_item_t r;
            if (it.new_frame)
                slot = slot + 2'd1;
            row = int'(it.point_index) % POINTS;
            if (it.sample_valid)
            begin
                hist_x[int'(slot)*POINTS + row] = it.x_value;
                hist_y[int'(slot)*POINTS + row] = it.y_value;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                idx   = ((int'(slot) - i) & 3) * POINTS + row;
                qx[i] = hist_x[idx];
                qy[i] = hist_y[idx];
            end
            for (int j = 0; j < SUBSTEPS; j++)
            begin
                k           = (j * Q_ONE + SUBSTEPS / 2) / SUBSTEPS;
                r.x_out     = sample_t'(eval_curve(qx, k));
                r.y_out     = sample_t'(eval_curve(qy, k));
                r.out_point = it.point_index;
                r.sub_index = SUB_W'(j);
                r.last      = (j == SUBSTEPS - 1);
                expected_steps.push_back(r);
            end
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_step(out_item_t got);
            out_item_t want;
            if (expected_steps.size() == 0)
            begin
                report($sformatf("unexpected beat point %0d sub %0d",
                                 got.out_point, got.sub_index));
                return;
            end
            want = expected_steps.pop_front();
            if (got.x_out !== want.x_out)
                report($sformatf("x_out %0d, want %0d (point %0d sub %0d)",
                                 got.x_out, want.x_out, want.out_point, want.sub_index));
            if (got.y_out !== want.y_out)
                report($sformatf("y_out %0d, want %0d (point %0d sub %0d)",
                                 got.y_out, want.y_out, want.out_point, want.sub_index));
            if (got.out_point !== want.out_point)
                report($sformatf("out_point %0d, want %0d", got.out_point, want.out_point));
            if (got.sub_index !== want.sub_index)
                report($sformatf("sub_index %0d, want %0d", got.sub_index, want.sub_index));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b (sub %0d)",
                                 got.last, want.last, want.sub_index));
        endtask

        task close_out();
            if (expected_steps.size() != 0)
                report($sformatf("%0d result beats never arrived", expected_steps.size()));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    in_item_t     item;
    logic         result_valid;
    logic         result_ready;
    out_item_t    result;

    curve_checker chk;
    int           tx_seq;
    bit           tx_calm;
    int           idle_cycles;
    logic [PW-1:0] pool [6];

    cubic_bezier_frame_interp dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_item(input sample_t x, input sample_t y, input logic [PW-1:0] p,
                             input logic v, input logic nf);
        in_item_t it;
        int       gap;
        it.x_value      = x;
        it.y_value      = y;
        it.point_index  = p;
        it.sample_valid = v;
        it.new_frame    = nf;
        tx_seq++;
        if (tx_seq % 16 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        chk.note_item(it);
    endtask

    // result side: random stalls, calm stretches, one long hold to back up the block
    initial
    begin : result_sink
        int gap;
        int rx_count;
        bit rx_calm;
        rx_count     = 0;
        rx_calm      = 1'b0;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_count % 64 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_count == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            chk.check_step(result);
            rx_count++;
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int       n;
        int       frame_len;
        logic [PW-1:0] p;
        chk          = new();
        tx_seq       = 0;
        tx_calm      = 1'b0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // fill one point's history with extremes, then walk the special cases
        send_item(S_MAX, S_MIN, 9'd5, 1'b1, 1'b1);
        send_item(S_MIN, S_MAX, 9'd5, 1'b1, 1'b1);
        send_item(S_MAX, S_MAX, 9'd5, 1'b1, 1'b1);
        send_item(S_MIN, S_MIN, 9'd5, 1'b1, 1'b1);
        send_item(16'sh1234, -16'sd77, 9'd5, 1'b0, 1'b0);
        send_item(16'sh0F0F, 16'sh7070, 9'd5, 1'b0, 1'b1);
        send_item(-16'sd1, 16'sd1, 9'd511, 1'b1, 1'b0);
        send_item(16'sd0, -16'sd1, 9'd0, 1'b1, 1'b0);
        send_item(16'sh5555, 16'shAAAA, 9'd170, 1'b1, 1'b0);
        send_item(16'shAAAA, 16'sh5555, 9'd341, 1'b1, 1'b0);
        send_item(16'sd1, -16'sd1, 9'd5, 1'b1, 1'b0);
        send_item(-16'sd1, 16'sd1, 9'd5, 1'b1, 1'b1);
        send_item(16'sd1, -16'sd1, 9'd5, 1'b1, 1'b1);
        send_item(S_MAX, S_MAX, 9'd511, 1'b1, 1'b1);
        send_item(S_MIN, S_MIN, 9'd511, 1'b1, 1'b1);
        send_item(S_MAX, S_MIN, 9'd511, 1'b0, 1'b1);
        send_item(16'sd3, 16'sd2, 9'd256, 1'b1, 1'b0);
        send_item(S_MIN, S_MAX, 9'd0, 1'b1, 1'b0);

        // mostly whole frames over a small point pool, some noise beats
        foreach (pool[i])
            pool[i] = PW'($urandom_range(0, POINTS - 1));
        pool[0] = 9'd511;
        pool[1] = 9'd0;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(sample_t'($urandom), sample_t'($urandom),
                          PW'($urandom_range(0, POINTS - 1)),
                          1'($urandom), 1'($urandom));
                n++;
            end
            else
            begin
                frame_len = $urandom_range(1, 5);
                for (int i = 0; i < frame_len; i++)
                begin
                    p = ($urandom_range(0, 15) == 0) ? PW'($urandom_range(0, POINTS - 1))
                                                     : pool[$urandom_range(0, 5)];
                    send_item(pick_sample(), pick_sample(), p,
                              $urandom_range(0, 7) != 0, i == 0);
                    n++;
                end
            end
        end
        item_valid <= 1'b0;

        while (chk.expected_steps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        chk.close_out();
        if (chk.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cbfi_pkg.sv
rtl/cbfi_history.sv
rtl/cbfi_curve_gen.sv
rtl/cubic_bezier_frame_interp.sv
rtl/cbfi_checker.sv
tb/sv/tb_top.sv
